>>> hdl/fixed_partition_placement_unit_defines.svh
// assertion macros shared by the checker
`ifndef FIXED_PARTITION_PLACEMENT_UNIT_DEFINES_SVH
`define FIXED_PARTITION_PLACEMENT_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FPPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fppu check failed");

// next-cycle implication, disabled in reset
`define FPPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fppu check failed");

`endif

>>> hdl/fppu_pkg.sv
`default_nettype none
package fppu_pkg;

  localparam int DEF_MAX_PARTITIONS = 64;
  localparam int DEF_SIZE_BITS      = 16;

  localparam int OPC_W    = 3;
  localparam int PIDX_W   = 6;
  localparam int AMOUNT_W = 16;
  localparam int ACTIVE_W = 7;
  localparam int OIDX_W   = 6;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic [OPC_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OPC_W-1:0] OP_FIRST = 3'd1;
  localparam logic [OPC_W-1:0] OP_BEST  = 3'd2;
  localparam logic [OPC_W-1:0] OP_WORST = 3'd3;
  localparam logic [OPC_W-1:0] OP_NEXT  = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_COMMIT
  } state_t;

endpackage
`default_nettype wire

>>> hdl/fixed_partition_placement_unit.sv
`default_nettype none
// fixed partition placement unit: keeps a table of partitions (size plus taken
// mark) in one synchronous memory. A load transaction writes a size and frees
// the entry; an allocate transaction (first, best, worst or next fit) scans the
// active entries through the memory read port, one entry per cycle, then writes
// the chosen entry back as taken. Every transaction gives exactly one result,
// shown for one cycle with out_strobe; the receiver cannot stall, so results
// must be captured when the strobe is high. A new transaction is taken while
// busy is low. An allocate scans entries s to n - 1, where n is
// min(active_partitions, MAX_PARTITIONS) and s is 0, or the position after the
// last allocation for next fit. An allocate with nothing to scan answers at
// once. After reset the block runs a clearing pass over the taken marks with
// busy high; configuration writes are taken throughout.
module fixed_partition_placement_unit
  import fppu_pkg::*;
#(
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = DEF_SIZE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OPC_W-1:0]    in_opcode,
  input  wire logic [PIDX_W-1:0]   in_part_index,
  input  wire logic [AMOUNT_W-1:0] in_amount,
  output logic                     out_strobe,
  output logic                     out_granted,
  output logic [OIDX_W-1:0]        out_granted_index,
  input  wire logic                cfg_wr_en,
  input  wire logic [ACTIVE_W-1:0] cfg_wr_data
);

  // entry index width and width of a count that can hold MAX_PARTITIONS
  localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
  localparam int CMP_W  = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam int WORD_W = SIZE_BITS + 1;

  // partition table: {taken, size}
  logic [WORD_W-1:0] mem [MAX_PARTITIONS];
  logic [WORD_W-1:0] mem_q_r;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]     addr_r, addr_nxt;      // scan / clear address
  logic [IDX_W-1:0]     last_r, last_nxt;      // last entry of the scan
  logic                 rd_vld_r, rd_vld_nxt;  // mem_q_r holds a scanned entry
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_size_r, best_size_nxt;
  logic [OPC_W-1:0]     mode_r, mode_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [CNT_W-1:0]     next_start_r, next_start_nxt;
  logic [ACTIVE_W-1:0]  active_r;

  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic [OIDX_W-1:0]    out_index_r, out_index_nxt;

  // scan bounds
  logic [CMP_W-1:0]     active_ext;
  logic [CNT_W-1:0]     scan_n;
  logic [CNT_W-1:0]     scan_start;
  logic                 load_ok;
  logic                 accept;

  // evaluation of the entry read last cycle
  logic                 q_taken;
  logic [SIZE_BITS-1:0] q_size;
  logic                 q_fit;
  logic                 q_take;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign active_ext = CMP_W'(active_r);
  assign scan_n     = (active_ext > CMP_W'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS)
                                                            : CNT_W'(active_ext);
  assign scan_start = (in_opcode == OP_NEXT) ? next_start_r : '0;
  assign load_ok    = CMP_W'(in_part_index) < CMP_W'(MAX_PARTITIONS);

  assign q_taken = mem_q_r[SIZE_BITS];
  assign q_size  = mem_q_r[SIZE_BITS-1:0];
  assign q_fit   = !q_taken && (q_size >= req_r);
  // first and next fit keep the earliest hit; best / worst replace on strict
  // improvement only, so ties stay at the lowest index
  assign q_take  = rd_vld_r && q_fit &&
                   (!found_r ||
                    ((mode_r == OP_BEST)  && (q_size < best_size_r)) ||
                    ((mode_r == OP_WORST) && (q_size > best_size_r)));

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[addr_r];
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      next_start_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
      next_start_r <= next_start_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r        <= last_nxt;
    rd_idx_r      <= addr_r;
    best_idx_r    <= best_idx_nxt;
    best_size_r   <= best_size_nxt;
    mode_r        <= mode_nxt;
    req_r         <= req_nxt;
    out_granted_r <= out_granted_nxt;
    out_index_r   <= out_index_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    last_nxt        = last_r;
    rd_vld_nxt      = 1'b0;
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_size_nxt   = best_size_r;
    mode_nxt        = mode_r;
    req_nxt         = req_r;
    next_start_nxt  = next_start_r;
    out_strobe_nxt  = 1'b0;
    out_granted_nxt = 1'b0;
    out_index_nxt   = '0;
    wr_en           = 1'b0;
    wr_addr         = addr_r;
    wr_data         = '0;

    // running pick from the entry that came back from memory
    if (q_take) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = rd_idx_r;
      best_size_nxt = q_size;
    end

    case (state_r)
      ST_CLEAR: begin
        // free every entry once after reset
        wr_en = 1'b1;
        if (addr_r == IDX_W'(MAX_PARTITIONS - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_LOAD: begin
              out_strobe_nxt = 1'b1;
              if (load_ok) begin
                wr_en           = 1'b1;
                wr_addr         = IDX_W'(in_part_index);
                wr_data         = {1'b0, SIZE_BITS'(in_amount)};
                out_granted_nxt = 1'b1;
                out_index_nxt   = in_part_index;
              end
            end
            OP_FIRST, OP_BEST, OP_WORST, OP_NEXT: begin
              mode_nxt  = in_opcode;
              req_nxt   = SIZE_BITS'(in_amount);
              found_nxt = 1'b0;
              if (scan_start < scan_n) begin
                addr_nxt  = IDX_W'(scan_start);
                last_nxt  = IDX_W'(scan_n - 1'b1);
                state_nxt = ST_SCAN;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read at addr_r is issued this cycle
        rd_vld_nxt = 1'b1;
        if (addr_r == last_r) begin
          state_nxt = ST_WAIT;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_WAIT: begin
        // last entry is evaluated here
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
        if (found_r) begin
          wr_en           = 1'b1;
          wr_addr         = best_idx_r;
          wr_data         = {1'b1, best_size_r};
          next_start_nxt  = CNT_W'(best_idx_r) + 1'b1;
          out_granted_nxt = 1'b1;
          out_index_nxt   = OIDX_W'(best_idx_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_strobe        = out_strobe_r;
  assign out_granted       = out_granted_r;
  assign out_granted_index = out_index_r;

endmodule
`default_nettype wire

>>> hdl/fppu_checker.sv
`default_nettype none
`include "fixed_partition_placement_unit_defines.svh"
module fppu_checker
  import fppu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_strobe,
  input wire logic              out_granted,
  input wire logic [OIDX_W-1:0] out_granted_index
);

  // a refused request reports index zero
  `FPPU_ASSERT_NOW(a_nogrant_idx, clk, rst_n, out_strobe && !out_granted, out_granted_index == '0)

  // every accepted transaction either keeps the unit busy or answers next cycle
  `FPPU_ASSERT_NEXT(a_accept_prog, clk, rst_n, start && !busy, busy || out_strobe)

  // a result closes its transaction, so the unit is free when it shows
  `FPPU_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_strobe, !busy)

  // no result appears out of an idle cycle with no transaction
  `FPPU_ASSERT_NEXT(a_no_spurious, clk, rst_n, !busy && !start, !out_strobe)

endmodule

bind fixed_partition_placement_unit fppu_checker u_fppu_checker (.*);
`default_nettype wire
